@@ sv/assert_macros.svh @@
// Assertion macros shared by the vector normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge while out of reset.
`define VN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("vector2_normalize assertion failed");
// Check that a condition is never true while out of reset.
`define VN_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `VN_ASSERT(lbl, clk, rstn, !(cond))
`else
`define VN_ASSERT(lbl, clk, rstn, prop)
`define VN_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ sv/vn_pkg.sv @@
// Shared constants for the 2-D vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;

  // Default component width and fraction bits of the unit vector
  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  // Queue depths between the parts
  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 2;

endpackage

@@ sv/vector2_normalize.sv @@
// Top level of the 2-D vector normalizer.
//
//  channel  | handshake     | beat fields
//  ---------+---------------+-------------------------------------------------
//  input    | push / full   | comp_x_i, comp_y_i
//  result   | pop / empty   | unit_x_o, unit_y_o, magnitude_o, zero_vector_o
//
// One vector enters per cycle while full is low, and one result leaves per cycle while empty is low.
// The square-root pipe has COMP_WIDTH+3 stages and the divider pipe FRAC_BITS+1;
// each pipe writes its beats into its own queue.
// The root and the divider each resolve one bit per stage.
// Each pipe stalls as a whole only when its last beat finds its queue full.
// Reset empties the queues and clears the valid bits; no clearing pass.
`timescale 1ns / 1ps
module vector2_normalize #(
  parameter int unsigned COMP_WIDTH = vn_pkg::COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = vn_pkg::FRAC_BITS_DEF,
  parameter int unsigned MID_DEPTH  = vn_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH  = vn_pkg::OUT_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COMP_WIDTH-1:0] comp_x_i,
  input  logic signed [COMP_WIDTH-1:0] comp_y_i,
  input  logic                         pop,
  output logic                         empty,
  output logic signed [COMP_WIDTH-1:0] unit_x_o,
  output logic signed [COMP_WIDTH-1:0] unit_y_o,
  output logic        [COMP_WIDTH-1:0] magnitude_o,
  output logic                         zero_vector_o
);
  import vn_pkg::*;

  localparam int unsigned MID_W = 3 * COMP_WIDTH + 3;
  localparam int unsigned OUT_W = 3 * COMP_WIDTH + 1;

  logic             f_push, m_full, m_empty, b_pop, b_push, o_full;
  logic [MID_W-1:0] f_data, m_data;
  logic [OUT_W-1:0] b_data, o_data;

  vn_front #(.W(COMP_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .push_i   (push),
    .comp_x_i (comp_x_i),
    .comp_y_i (comp_y_i),
    .full_o   (full),
    .push_o   (f_push),
    .data_o   (f_data),
    .full_i   (m_full)
  );

  vn_fifo #(.DATA_W(MID_W), .DEPTH(MID_DEPTH)) u_mid (
    .clk_i, .rst_ni,
    .push_i  (f_push),
    .data_i  (f_data),
    .full_o  (m_full),
    .pop_i   (b_pop),
    .data_o  (m_data),
    .empty_o (m_empty)
  );

  vn_back #(.W(COMP_WIDTH), .F(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i (m_empty),
    .data_i  (m_data),
    .pop_o   (b_pop),
    .push_o  (b_push),
    .data_o  (b_data),
    .full_i  (o_full)
  );

  vn_fifo #(.DATA_W(OUT_W), .DEPTH(OUT_DEPTH)) u_out (
    .clk_i, .rst_ni,
    .push_i  (b_push),
    .data_i  (b_data),
    .full_o  (o_full),
    .pop_i   (pop),
    .data_o  (o_data),
    .empty_o (empty)
  );

  // Unpack the oldest result
  assign {unit_x_o, unit_y_o, magnitude_o, zero_vector_o} = o_data;

endmodule

@@ sv/vn_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vn_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);
  import vn_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              wr, rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `VN_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CNT_W'(DEPTH))
  `VN_ASSERT(a_cnt_step, clk_i, rst_ni, (wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

@@ sv/vn_front.sv @@
// Front part: magnitudes, squares and pipelined integer square root.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vn_front #(
  parameter int unsigned W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [W-1:0]     comp_x_i,
  input  logic [W-1:0]     comp_y_i,
  output logic             full_o,
  output logic             push_o,
  output logic [3*W+2:0]   data_o,
  input  logic             full_i
);
  import vn_pkg::*;

  localparam int unsigned NF = W + 3;

  logic           en;
  logic           v_q  [NF];
  logic [W-1:0]   mx_q [NF];
  logic [W-1:0]   my_q [NF];
  logic           nx_q [NF];
  logic           ny_q [NF];
  logic           z_q  [NF];
  logic [2*W-1:0] sqx_q, sqy_q, sum_q;
  logic [2*W-1:0] s_q    [W];
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [W-1:0]   abs_x, abs_y;

  // Stall the whole pipe only when its last beat cannot leave
  assign en     = !v_q[NF-1] || !full_i;
  assign full_o = !en;
  assign push_o = v_q[NF-1];
  assign data_o = {z_q[NF-1], nx_q[NF-1], ny_q[NF-1], mx_q[NF-1], my_q[NF-1],
                   root_q[W-1]};

  assign abs_x = comp_x_i[W-1] ? (~comp_x_i + 1'b1) : comp_x_i;
  assign abs_y = comp_y_i[W-1] ? (~comp_y_i + 1'b1) : comp_y_i;

  for (genvar k = 0; k < NF; k++) begin : g_stage
    if (k == 0) begin : g_first
      // Take a valid bit from the input handshake
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en) begin
          v_q[k] <= push_i;
        end
      end
      // Capture magnitudes, signs and zero flag
      always_ff @(posedge clk_i) begin
        if (en) begin
          mx_q[k] <= abs_x;
          my_q[k] <= abs_y;
          nx_q[k] <= comp_x_i[W-1];
          ny_q[k] <= comp_y_i[W-1];
          z_q[k]  <= (comp_x_i == '0) && (comp_y_i == '0);
        end
      end
    end else begin : g_rest
      // Advance valid bits
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en) begin
          v_q[k] <= v_q[k-1];
        end
      end
      // Carry magnitudes, signs and zero flag along
      always_ff @(posedge clk_i) begin
        if (en) begin
          mx_q[k] <= mx_q[k-1];
          my_q[k] <= my_q[k-1];
          nx_q[k] <= nx_q[k-1];
          ny_q[k] <= ny_q[k-1];
          z_q[k]  <= z_q[k-1];
        end
      end
    end
  end

  // Square the magnitudes, then add
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= mx_q[0] * mx_q[0];
      sqy_q <= my_q[0] * my_q[0];
      sum_q <= sqx_q + sqy_q;
    end
  end

  // One root bit per stage
  for (genvar j = 0; j < W; j++) begin : g_sqrt
    logic [2*W-1:0] s_in;
    logic [W+1:0]   rem_in, rem_t, trial;
    logic [W-1:0]   root_in;
    if (j == 0) begin : g_init
      assign s_in    = sum_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_chain
      assign s_in    = s_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end
    assign rem_t = {rem_in[W-1:0], s_in[2*W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_q[j] <= {s_in[2*W-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_q[j]  <= rem_t - trial;
          root_q[j] <= {root_in[W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_t;
          root_q[j] <= {root_in[W-2:0], 1'b0};
        end
      end
    end
  end

  `VN_ASSERT(a_hold_stalled, clk_i, rst_ni, (v_q[NF-1] && full_i) |=> v_q[NF-1])

endmodule

@@ sv/vn_back.sv @@
// Back part: pipelined fixed-point division of both components by the length.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vn_back #(
  parameter int unsigned W = 16,
  parameter int unsigned F = 14
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  logic [3*W+2:0] data_i,
  output logic           pop_o,
  output logic           push_o,
  output logic [3*W:0]   data_o,
  input  logic           full_i
);
  import vn_pkg::*;

  localparam int unsigned NB = F + 1;
  localparam int unsigned EW = ((W > F + 1) ? W : F + 1) + 1;

  logic           en;
  logic           v_q   [NB];
  logic [W-1:0]   len_q [NB];
  logic           nx_q  [NB];
  logic           ny_q  [NB];
  logic           z_q   [NB];
  logic [W:0]     rx_q  [NB];
  logic [W:0]     ry_q  [NB];
  logic [F:0]     qx_q  [NB];
  logic [F:0]     qy_q  [NB];
  logic           in_z, in_nx, in_ny;
  logic [W-1:0]   in_mx, in_my, in_len;
  logic [EW-1:0]  qx_ext, qy_ext, ux, uy;
  logic [W-1:0]   unit_x, unit_y;

  assign {in_z, in_nx, in_ny, in_mx, in_my, in_len} = data_i;

  // Stall the whole pipe only when its last beat cannot leave
  assign en     = !v_q[NB-1] || !full_i;
  assign pop_o  = en && !empty_i;
  assign push_o = v_q[NB-1];

  // Apply signs; a zero vector passes its zero components
  assign qx_ext = EW'(qx_q[NB-1]);
  assign qy_ext = EW'(qy_q[NB-1]);
  assign ux     = nx_q[NB-1] ? (~qx_ext + 1'b1) : qx_ext;
  assign uy     = ny_q[NB-1] ? (~qy_ext + 1'b1) : qy_ext;
  assign unit_x = z_q[NB-1] ? '0 : ux[W-1:0];
  assign unit_y = z_q[NB-1] ? '0 : uy[W-1:0];
  assign data_o = {unit_x, unit_y, len_q[NB-1], z_q[NB-1]};

  // One quotient bit per stage for each component
  for (genvar j = 0; j < NB; j++) begin : g_div
    logic           v_in, nx_in, ny_in, z_in;
    logic [W-1:0]   len_in;
    logic [W:0]     rx_in, ry_in, tx, ty, dv;
    logic [F:0]     qx_in, qy_in;
    logic           bx, by;
    if (j == 0) begin : g_init
      assign v_in   = !empty_i;
      assign len_in = in_len;
      assign nx_in  = in_nx;
      assign ny_in  = in_ny;
      assign z_in   = in_z;
      assign rx_in  = {2'b00, in_mx[W-1:1]};
      assign ry_in  = {2'b00, in_my[W-1:1]};
      assign bx     = in_mx[0];
      assign by     = in_my[0];
      assign qx_in  = '0;
      assign qy_in  = '0;
    end else begin : g_chain
      assign v_in   = v_q[j-1];
      assign len_in = len_q[j-1];
      assign nx_in  = nx_q[j-1];
      assign ny_in  = ny_q[j-1];
      assign z_in   = z_q[j-1];
      assign rx_in  = rx_q[j-1];
      assign ry_in  = ry_q[j-1];
      assign bx     = 1'b0;
      assign by     = 1'b0;
      assign qx_in  = qx_q[j-1];
      assign qy_in  = qy_q[j-1];
    end
    assign tx = {rx_in[W-1:0], bx};
    assign ty = {ry_in[W-1:0], by};
    assign dv = {1'b0, len_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        len_q[j] <= len_in;
        nx_q[j]  <= nx_in;
        ny_q[j]  <= ny_in;
        z_q[j]   <= z_in;
        if (tx >= dv) begin
          rx_q[j] <= tx - dv;
          qx_q[j] <= {qx_in[F-1:0], 1'b1};
        end else begin
          rx_q[j] <= tx;
          qx_q[j] <= {qx_in[F-1:0], 1'b0};
        end
        if (ty >= dv) begin
          ry_q[j] <= ty - dv;
          qy_q[j] <= {qy_in[F-1:0], 1'b1};
        end else begin
          ry_q[j] <= ty;
          qy_q[j] <= {qy_in[F-1:0], 1'b0};
        end
      end
    end
  end

  `VN_ASSERT(a_zero_len, clk_i, rst_ni, (v_q[NB-1] && z_q[NB-1]) |-> (len_q[NB-1] == '0))
  `VN_ASSERT(a_hold_stalled, clk_i, rst_ni, (v_q[NB-1] && full_i) |=> v_q[NB-1])

endmodule
